### hw/rtl/osl_pkg.sv
`timescale 1ns / 1ps
// osl_pkg: shared widths, constants and types of the obstacle-aware speed limiter
// used by every module under hw/rtl, depends on nothing

package osl_pkg;

    // heading window depth, legal range 2 to 32
    localparam int WINDOW_DEPTH = 7;

    localparam int RANGE_W   = 13;
    localparam int ANGLE_W   = 9;
    localparam int SPEED_IN_W = 8;
    localparam int GAIN_W    = 16;
    localparam int CFG_IDX_W = 2;

    // largest negated heading after saturation
    localparam int NEG_MAX   = 255;

    // running sum keeps any depth without wrapping
    localparam int MAG_W  = $clog2(WINDOW_DEPTH * NEG_MAX + 1);
    localparam int SUM_W  = MAG_W + 1;
    localparam int PROD_W = MAG_W + GAIN_W;
    localparam int NUM_W  = PROD_W + 2;

    // common signed width for intermediate speeds (obstacle speed reaches 819)
    localparam int SPEED_W = 12;

    localparam int MIN_SPEED = 10;
    localparam int SLEW_STEP = 1;

    // divide by ten: (x * 52429) >> 19, exact for 13-bit x
    localparam logic [15:0] DIV10_MUL = 16'd52429;
    localparam int DIV10_SHIFT = 19;
    localparam int QUOT_W = 10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEADING_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_ZONE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_ZONE    = 2'd2;

    localparam logic [GAIN_W-1:0]  GAIN_RESET      = 16'd256;
    localparam logic [RANGE_W-1:0] SLOW_ZONE_RESET = 13'd400;
    localparam logic [RANGE_W-1:0] STOP_ZONE_RESET = 13'd150;

    typedef struct packed {
        logic [GAIN_W-1:0]  heading_gain_q8;
        logic [RANGE_W-1:0] slow_zone_mm;
        logic [RANGE_W-1:0] stop_zone_mm;
    } osl_cfg_t;

    typedef struct packed {
        logic                       is_obstacle;
        logic signed [SPEED_W-1:0]  speed;
    } osl_obs_t;

endpackage

### hw/rtl/osl_obstacle.sv
`timescale 1ns / 1ps
// osl_obstacle: weighted minimum range and distance-following speed
// depends on osl_pkg

module osl_obstacle (
    input  logic [osl_pkg::RANGE_W-1:0] range_mid_left,
    input  logic [osl_pkg::RANGE_W-1:0] range_center,
    input  logic [osl_pkg::RANGE_W-1:0] range_mid_right,
    input  logic [osl_pkg::RANGE_W-1:0] range_outer_left,
    input  logic [osl_pkg::RANGE_W-1:0] range_outer_right,
    input  osl_pkg::osl_cfg_t           cfg,
    output osl_pkg::osl_obs_t           obs
);

    localparam int WIDE_W = osl_pkg::RANGE_W + 2;
    localparam int DPROD_W = osl_pkg::RANGE_W + 16;

    logic [WIDE_W-1:0]              outer_left_x3;
    logic [WIDE_W-1:0]              outer_right_x3;
    logic [WIDE_W-1:0]              near_wide;
    logic [osl_pkg::RANGE_W-1:0]    near_mm;
    logic [DPROD_W-1:0]             div_prod;
    logic [osl_pkg::QUOT_W-1:0]     quot;

    always_comb begin
        outer_left_x3  = {2'b00, range_outer_left} + {1'b0, range_outer_left, 1'b0};
        outer_right_x3 = {2'b00, range_outer_right} + {1'b0, range_outer_right, 1'b0};

        near_wide = WIDE_W'(range_mid_left);
        if (WIDE_W'(range_center) < near_wide) begin
            near_wide = WIDE_W'(range_center);
        end
        if (WIDE_W'(range_mid_right) < near_wide) begin
            near_wide = WIDE_W'(range_mid_right);
        end
        if (outer_left_x3 < near_wide) begin
            near_wide = outer_left_x3;
        end
        if (outer_right_x3 < near_wide) begin
            near_wide = outer_right_x3;
        end
        // never above the centre readings, so 13 bits hold it
        near_mm = near_wide[osl_pkg::RANGE_W-1:0];

        div_prod = DPROD_W'(near_mm) * DPROD_W'(osl_pkg::DIV10_MUL);
        quot = div_prod[osl_pkg::DIV10_SHIFT +: osl_pkg::QUOT_W];

        obs.is_obstacle = (near_mm < cfg.slow_zone_mm);
        if (near_mm > cfg.stop_zone_mm) begin
            if (quot < osl_pkg::QUOT_W'(osl_pkg::MIN_SPEED)) begin
                obs.speed = osl_pkg::SPEED_W'(osl_pkg::MIN_SPEED);
            end else begin
                obs.speed = osl_pkg::SPEED_W'(quot);
            end
        end else begin
            obs.speed = '0;
        end
    end

endmodule

### hw/rtl/osl_heading.sv
`timescale 1ns / 1ps
// osl_heading: heading window with running sum, gain reduction and slew limit
// depends on osl_pkg

module osl_heading (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  commit,
    input  logic signed [osl_pkg::ANGLE_W-1:0]    heading_angle,
    input  logic signed [osl_pkg::SPEED_IN_W-1:0] current_speed,
    input  logic signed [osl_pkg::SPEED_IN_W-1:0] speed_limit,
    input  logic [osl_pkg::GAIN_W-1:0]            heading_gain_q8,
    output logic signed [osl_pkg::SPEED_W-1:0]    speed
);

    localparam int D = osl_pkg::WINDOW_DEPTH;

    logic signed [osl_pkg::ANGLE_W-1:0] window_reg [D];
    logic signed [osl_pkg::SUM_W-1:0]   sum_reg;
    logic signed [osl_pkg::SUM_W-1:0]   sum_next;

    logic signed [osl_pkg::ANGLE_W-1:0] neg;
    logic [osl_pkg::MAG_W-1:0]          mag;
    logic [osl_pkg::PROD_W-1:0]         prod;
    logic signed [osl_pkg::NUM_W-1:0]   lim_wide;
    logic signed [osl_pkg::NUM_W-1:0]   prod_wide;
    logic signed [osl_pkg::NUM_W-1:0]   num;
    logic signed [osl_pkg::NUM_W-1:0]   bias;
    logic signed [osl_pkg::NUM_W-1:0]   quo;
    logic signed [osl_pkg::SPEED_W-1:0] floored;
    logic signed [osl_pkg::SPEED_W-1:0] cur;
    logic signed [osl_pkg::SPEED_W-1:0] diff;

    always_comb begin
        // most negative angle saturates when negated
        if (heading_angle == {1'b1, {(osl_pkg::ANGLE_W-1){1'b0}}}) begin
            neg = osl_pkg::ANGLE_W'(osl_pkg::NEG_MAX);
        end else begin
            neg = -heading_angle;
        end

        sum_next = sum_reg - osl_pkg::SUM_W'(window_reg[D-1]) + osl_pkg::SUM_W'(neg);

        if (sum_next < 0) begin
            mag = osl_pkg::MAG_W'(-sum_next);
        end else begin
            mag = osl_pkg::MAG_W'(sum_next);
        end

        prod = osl_pkg::PROD_W'(mag) * osl_pkg::PROD_W'(heading_gain_q8);

        lim_wide  = osl_pkg::NUM_W'(speed_limit);
        prod_wide = osl_pkg::NUM_W'(prod);
        num = (lim_wide <<< 8) - prod_wide;

        // truncate toward zero
        bias = '0;
        if (num < 0) begin
            bias = osl_pkg::NUM_W'(255);
        end
        quo = (num + bias) >>> 8;

        if (quo < osl_pkg::MIN_SPEED) begin
            floored = osl_pkg::SPEED_W'(osl_pkg::MIN_SPEED);
        end else begin
            floored = osl_pkg::SPEED_W'(quo);
        end

        cur  = osl_pkg::SPEED_W'(current_speed);
        diff = floored - cur;
        if (diff > osl_pkg::SLEW_STEP) begin
            speed = cur + osl_pkg::SPEED_W'(osl_pkg::SLEW_STEP);
        end else if (diff < -osl_pkg::SLEW_STEP) begin
            speed = cur - osl_pkg::SPEED_W'(osl_pkg::SLEW_STEP);
        end else begin
            speed = floored;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < D; i++) begin
                window_reg[i] <= '0;
            end
            sum_reg <= '0;
        end else if (commit) begin
            window_reg[0] <= neg;
            for (int i = 1; i < D; i++) begin
                window_reg[i] <= window_reg[i-1];
            end
            sum_reg <= sum_next;
        end
    end

endmodule

### hw/rtl/obstacle_aware_speed_limiter_top.sv
`timescale 1ns / 1ps
// obstacle_aware_speed_limiter_top: input register, speed logic, result register
// depends on osl_pkg, osl_obstacle, osl_heading
//
// channel   direction  handshake            payload
// s_        in         s_valid / s_ready    five ranges, heading angle, current speed, limit
// m_        out        m_valid / m_ready    speed command
// cfg_      in         cfg_valid / cfg_ready  register index and write data
//
// result goes via input and result registers; one item per cycle while m_ready stays high
// the input register feeds the result register through the speed logic
// aresetn (synchronous) clears valid flags, window and sum; presets the config registers
// a stalled result holds the result register; the input register still takes an item
// while it is empty or the result register is empty or being taken in the same cycle

module obstacle_aware_speed_limiter_top (
    input  logic                                   aclk,
    input  logic                                   aresetn,

    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [osl_pkg::RANGE_W-1:0]            s_range_mid_left,
    input  logic [osl_pkg::RANGE_W-1:0]            s_range_center,
    input  logic [osl_pkg::RANGE_W-1:0]            s_range_mid_right,
    input  logic [osl_pkg::RANGE_W-1:0]            s_range_outer_left,
    input  logic [osl_pkg::RANGE_W-1:0]            s_range_outer_right,
    input  logic signed [osl_pkg::ANGLE_W-1:0]     s_heading_angle,
    input  logic signed [osl_pkg::SPEED_IN_W-1:0]  s_current_speed,
    input  logic signed [osl_pkg::SPEED_IN_W-1:0]  s_speed_limit,

    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [osl_pkg::SPEED_IN_W-1:0]  m_speed_command,

    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [osl_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [osl_pkg::GAIN_W-1:0]             cfg_data
);

    // configuration registers
    osl_pkg::osl_cfg_t cfg_reg;

    // input register
    logic                                   in_valid_reg;
    logic [osl_pkg::RANGE_W-1:0]            mid_left_reg;
    logic [osl_pkg::RANGE_W-1:0]            center_reg;
    logic [osl_pkg::RANGE_W-1:0]            mid_right_reg;
    logic [osl_pkg::RANGE_W-1:0]            outer_left_reg;
    logic [osl_pkg::RANGE_W-1:0]            outer_right_reg;
    logic signed [osl_pkg::ANGLE_W-1:0]     angle_reg;
    logic signed [osl_pkg::SPEED_IN_W-1:0]  cur_reg;
    logic signed [osl_pkg::SPEED_IN_W-1:0]  limit_reg;

    // result register
    logic                                   out_valid_reg;
    logic signed [osl_pkg::SPEED_IN_W-1:0]  speed_cmd_reg;
    logic signed [osl_pkg::SPEED_IN_W-1:0]  speed_cmd_next;

    logic                                   advance;
    logic                                   commit;
    osl_pkg::osl_obs_t                      obs;
    logic signed [osl_pkg::SPEED_W-1:0]     heading_speed;
    logic signed [osl_pkg::SPEED_W-1:0]     chosen;
    logic signed [osl_pkg::SPEED_W-1:0]     limit_wide;

    // config writes always complete at once
    assign cfg_ready = 1'b1;

    // item in the input register moves on when the result register is free
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    // the heading window only moves on steps clear of obstacles
    assign commit  = advance && !obs.is_obstacle;

    osl_obstacle u_obstacle (
        .range_mid_left    (mid_left_reg),
        .range_center      (center_reg),
        .range_mid_right   (mid_right_reg),
        .range_outer_left  (outer_left_reg),
        .range_outer_right (outer_right_reg),
        .cfg               (cfg_reg),
        .obs               (obs)
    );

    osl_heading u_heading (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .commit          (commit),
        .heading_angle   (angle_reg),
        .current_speed   (cur_reg),
        .speed_limit     (limit_reg),
        .heading_gain_q8 (cfg_reg.heading_gain_q8),
        .speed           (heading_speed)
    );

    // pick the branch, then cap at the limit
    always_comb begin
        limit_wide = osl_pkg::SPEED_W'(limit_reg);
        if (obs.is_obstacle) begin
            chosen = obs.speed;
        end else begin
            chosen = heading_speed;
        end
        if (chosen > limit_wide) begin
            chosen = limit_wide;
        end
        // low byte, two's complement
        speed_cmd_next = chosen[osl_pkg::SPEED_IN_W-1:0];
    end

    // configuration writes, unknown indexes dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.heading_gain_q8 <= osl_pkg::GAIN_RESET;
            cfg_reg.slow_zone_mm    <= osl_pkg::SLOW_ZONE_RESET;
            cfg_reg.stop_zone_mm    <= osl_pkg::STOP_ZONE_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                osl_pkg::CFG_HEADING_GAIN: begin
                    cfg_reg.heading_gain_q8 <= cfg_data;
                end
                osl_pkg::CFG_SLOW_ZONE: begin
                    cfg_reg.slow_zone_mm <= cfg_data[osl_pkg::RANGE_W-1:0];
                end
                osl_pkg::CFG_STOP_ZONE: begin
                    cfg_reg.stop_zone_mm <= cfg_data[osl_pkg::RANGE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // input register valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // input payload, loaded on transfer
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            mid_left_reg    <= s_range_mid_left;
            center_reg      <= s_range_center;
            mid_right_reg   <= s_range_mid_right;
            outer_left_reg  <= s_range_outer_left;
            outer_right_reg <= s_range_outer_right;
            angle_reg       <= s_heading_angle;
            cur_reg         <= s_current_speed;
            limit_reg       <= s_speed_limit;
        end
    end

    // result register valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            speed_cmd_reg <= speed_cmd_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_speed_command = speed_cmd_reg;

endmodule
